// ----- rtl/dlh_pkg.sv -----
package dlh_pkg;

	localparam int ISR_DEPTH   = 1024;
	localparam int SCHED_DEPTH = 8192;
	localparam int COUNT_WIDTH = 24;

	localparam int ISR_AW    = $clog2(ISR_DEPTH);
	localparam int SCHED_AW  = $clog2(SCHED_DEPTH);
	localparam int HIST_AW   = (ISR_AW > SCHED_AW) ? ISR_AW : SCHED_AW;
	localparam int CLR_DEPTH = (ISR_DEPTH > SCHED_DEPTH) ? ISR_DEPTH : SCHED_DEPTH;
	localparam int CLR_AW    = $clog2(CLR_DEPTH);
	localparam int SUM_W     = COUNT_WIDTH + 1;

	localparam int ISR_RANGE_W   = 10;
	localparam int SCHED_RANGE_W = 13;
	localparam int PERIOD_W      = 24;
	localparam int LAT_W         = 16;
	localparam int BIN_IDX_W     = 13;
	localparam int MAXLAT_W      = 13;
	localparam int OP_W          = 2;
	localparam int PADDR_W       = 4;
	localparam int PDATA_W       = 32;

	localparam logic [ISR_RANGE_W-1:0]   ISR_RANGE_RST   = 10'd1000;
	localparam logic [SCHED_RANGE_W-1:0] SCHED_RANGE_RST = 13'd5000;
	localparam logic [PERIOD_W-1:0]      PERIOD_RST      = 24'd100;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE  = 2'd0,
		OP_READ    = 2'd1,
		OP_FINDMAX = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_ISR_RANGE   = 2'd0,
		REG_SCHED_RANGE = 2'd1,
		REG_PERIOD      = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SM_RD,
		ST_SM_WR,
		ST_RB_RD,
		ST_RB_CAP,
		ST_FM_RD,
		ST_FM_ACC,
		ST_CLR,
		ST_OVF,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [ISR_RANGE_W-1:0]   isr_range;
		logic [SCHED_RANGE_W-1:0] sched_range;
		logic [PERIOD_W-1:0]      period_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic accept_sample;
		logic clear_count;
		logic clr_step;
		logic rd_sample;
		logic wr_sample;
		logic cap_bin;
		logic fm_rd;
		logic fm_acc;
		logic rd_ovf;
	} cmd_t;

	typedef struct packed {
		logic sample_ok;
		logic clr_last;
		logic fm_stop;
	} sts_t;

	function automatic logic [31:0] eff_range(logic [31:0] reg_val, logic [31:0] depth);
		return (reg_val < depth - 32'd1) ? reg_val : depth - 32'd1;
	endfunction

	function automatic logic [31:0] clamp_val(logic [31:0] v, logic [31:0] range_val);
		return (v < range_val) ? v : range_val;
	endfunction

endpackage

// ----- rtl/dlh_regs.sv -----
module dlh_regs
	import dlh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.isr_range    <= ISR_RANGE_RST;
			cfg_q.sched_range  <= SCHED_RANGE_RST;
			cfg_q.period_limit <= PERIOD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ISR_RANGE:   cfg_q.isr_range    <= pwdata[ISR_RANGE_W-1:0];
				REG_SCHED_RANGE: cfg_q.sched_range  <= pwdata[SCHED_RANGE_W-1:0];
				REG_PERIOD:      cfg_q.period_limit <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ISR_RANGE:   prdata = PDATA_W'(cfg_q.isr_range);
			REG_SCHED_RANGE: prdata = PDATA_W'(cfg_q.sched_range);
			REG_PERIOD:      prdata = PDATA_W'(cfg_q.period_limit);
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- rtl/dlh_ctrl.sv -----
module dlh_ctrl
	import dlh_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] op,
	input  sts_t            sts,
	output cmd_t            cmd,
	output logic            busy,
	output logic            done
);

	state_t state_q;
	state_t state_d;
	op_t    op_in;

	assign op_in = op_t'(op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (op_in)
						OP_SAMPLE:  state_d = sts.sample_ok ? ST_SM_RD : ST_OVF;
						OP_READ:    state_d = ST_RB_RD;
						OP_FINDMAX: state_d = ST_FM_RD;
						OP_CLEAR:   state_d = ST_CLR;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_SM_RD:  state_d = ST_SM_WR;
			ST_SM_WR:  state_d = ST_OVF;
			ST_RB_RD:  state_d = ST_RB_CAP;
			ST_RB_CAP: state_d = ST_OVF;
			ST_FM_RD:  state_d = ST_FM_ACC;
			ST_FM_ACC: state_d = sts.fm_stop ? ST_OVF : ST_FM_RD;
			ST_CLR: begin
				if (sts.clr_last) state_d = ST_OVF;
			end
			ST_OVF:    state_d = ST_RESP;
			ST_RESP:   state_d = ST_IDLE;
			default:   state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_INIT: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				busy              = 1'b0;
				cmd.load          = start;
				cmd.accept_sample = start && (op_in == OP_SAMPLE) && sts.sample_ok;
				cmd.clear_count   = start && (op_in == OP_CLEAR);
			end
			ST_SM_RD:  cmd.rd_sample = 1'b1;
			ST_SM_WR:  cmd.wr_sample = 1'b1;
			ST_RB_RD:  ;
			ST_RB_CAP: cmd.cap_bin   = 1'b1;
			ST_FM_RD:  cmd.fm_rd     = 1'b1;
			ST_FM_ACC: cmd.fm_acc    = 1'b1;
			ST_CLR:    cmd.clr_step  = 1'b1;
			ST_OVF:    cmd.rd_ovf    = 1'b1;
			ST_RESP:   done          = 1'b1;
			default: ;
		endcase
	end

endmodule

// ----- rtl/dlh_dp.sv -----
module dlh_dp
	import dlh_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	input  logic [LAT_W-1:0]         isr_latency,
	input  logic [LAT_W-1:0]         sched_latency,
	input  logic                     which_hist,
	input  logic [BIN_IDX_W-1:0]     bin_index,
	output sts_t                     sts,
	output logic                     accepted,
	output logic [COUNT_WIDTH-1:0]   bin_count,
	output logic [MAXLAT_W-1:0]      max_latency,
	output logic [COUNT_WIDTH-1:0]   overflow_count,
	output logic [COUNT_WIDTH-1:0]   samples_taken
);

	logic [COUNT_WIDTH-1:0] isr_mem   [ISR_DEPTH];
	logic [COUNT_WIDTH-1:0] sched_mem [SCHED_DEPTH];

	logic [COUNT_WIDTH-1:0] isr_rdata_q;
	logic [COUNT_WIDTH-1:0] sched_rdata_q;
	logic [COUNT_WIDTH-1:0] sample_count_q;
	logic [CLR_AW-1:0]      clr_q;
	logic [HIST_AW-1:0]     ptr_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   which_q;
	logic [ISR_AW-1:0]      isr_addr_q;
	logic [SCHED_AW-1:0]    sched_addr_q;
	logic [HIST_AW-1:0]     idx_q;
	logic                   accepted_q;
	logic [COUNT_WIDTH-1:0] bin_count_q;
	logic [MAXLAT_W-1:0]    max_lat_q;

	logic [ISR_AW-1:0]      ir;
	logic [SCHED_AW-1:0]    sr;
	logic [HIST_AW-1:0]     range_sel;
	logic [HIST_AW-1:0]     range_in;
	logic [HIST_AW-1:0]     addr_sel;
	logic [ISR_AW-1:0]      isr_raddr;
	logic [SCHED_AW-1:0]    sched_raddr;
	logic                   isr_we;
	logic                   sched_we;
	logic [ISR_AW-1:0]      isr_waddr;
	logic [SCHED_AW-1:0]    sched_waddr;
	logic [COUNT_WIDTH-1:0] isr_wdata;
	logic [COUNT_WIDTH-1:0] sched_wdata;
	logic [COUNT_WIDTH-1:0] sel_rdata;
	logic [SUM_W-1:0]       sum_next;

	assign ir = ISR_AW'(eff_range(32'(cfg.isr_range), 32'(ISR_DEPTH)));
	assign sr = SCHED_AW'(eff_range(32'(cfg.sched_range), 32'(SCHED_DEPTH)));
	assign range_sel = which_q ? HIST_AW'(sr) : HIST_AW'(ir);
	assign range_in  = which_hist ? HIST_AW'(sr) : HIST_AW'(ir);

	assign sel_rdata = which_q ? sched_rdata_q : isr_rdata_q;
	assign sum_next  = sum_q + SUM_W'(sel_rdata);

	assign sts.sample_ok = (32'(sample_count_q) < 32'(cfg.period_limit))
		&& (sample_count_q != COUNT_MAX);
	assign sts.clr_last = (clr_q == CLR_AW'(CLR_DEPTH - 1));
	assign sts.fm_stop  = (sum_next >= SUM_W'(sample_count_q)) || (ptr_q == range_sel);

	always_comb begin
		if (cmd.rd_ovf) begin
			addr_sel = range_sel;
		end else if (cmd.fm_rd) begin
			addr_sel = ptr_q;
		end else begin
			addr_sel = idx_q;
		end
		isr_raddr   = cmd.rd_sample ? isr_addr_q : addr_sel[ISR_AW-1:0];
		sched_raddr = cmd.rd_sample ? sched_addr_q : addr_sel[SCHED_AW-1:0];
	end

	always_comb begin
		isr_we      = cmd.wr_sample
			|| (cmd.clr_step && ({1'b0, clr_q} < (CLR_AW + 1)'(ISR_DEPTH)));
		sched_we    = cmd.wr_sample
			|| (cmd.clr_step && ({1'b0, clr_q} < (CLR_AW + 1)'(SCHED_DEPTH)));
		isr_waddr   = cmd.clr_step ? clr_q[ISR_AW-1:0] : isr_addr_q;
		sched_waddr = cmd.clr_step ? clr_q[SCHED_AW-1:0] : sched_addr_q;
		if (cmd.clr_step) begin
			isr_wdata   = '0;
			sched_wdata = '0;
		end else begin
			isr_wdata   = (isr_rdata_q == COUNT_MAX) ? isr_rdata_q : isr_rdata_q + 1'b1;
			sched_wdata = (sched_rdata_q == COUNT_MAX) ? sched_rdata_q
				: sched_rdata_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (isr_we) begin
			isr_mem[isr_waddr] <= isr_wdata;
		end
		isr_rdata_q <= isr_mem[isr_raddr];
	end

	always_ff @(posedge clk) begin
		if (sched_we) begin
			sched_mem[sched_waddr] <= sched_wdata;
		end
		sched_rdata_q <= sched_mem[sched_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			sample_count_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= sts.clr_last ? '0 : clr_q + 1'b1;
			end
			if (cmd.clear_count) begin
				sample_count_q <= '0;
			end else if (cmd.wr_sample) begin
				sample_count_q <= sample_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			which_q      <= which_hist;
			isr_addr_q   <= ISR_AW'(clamp_val(32'(isr_latency), 32'(ir)));
			sched_addr_q <= SCHED_AW'(clamp_val(32'(sched_latency), 32'(sr)));
			idx_q        <= HIST_AW'(clamp_val(32'(bin_index), 32'(range_in)));
			accepted_q   <= cmd.accept_sample;
			bin_count_q  <= '0;
			max_lat_q    <= '0;
			ptr_q        <= '0;
			sum_q        <= '0;
		end else begin
			if (cmd.cap_bin) begin
				bin_count_q <= sel_rdata;
			end
			if (cmd.fm_acc) begin
				if (sts.fm_stop) begin
					max_lat_q <= MAXLAT_W'(32'(ptr_q));
				end else begin
					ptr_q <= ptr_q + 1'b1;
					sum_q <= sum_next;
				end
			end
		end
	end

	assign accepted       = accepted_q;
	assign bin_count      = bin_count_q;
	assign max_latency    = max_lat_q;
	assign overflow_count = sel_rdata;
	assign samples_taken  = sample_count_q;

endmodule

// ----- rtl/dual_latency_histogram_core.sv -----
// Channel   | Ports                                             | Handshake
// ----------+---------------------------------------------------+------------------------------
// request   | op, isr_latency, sched_latency, which_hist,       | taken when start && !busy
//           | bin_index                                         |
// result    | accepted, bin_count, max_latency, overflow_count, | valid for the one cycle done
//           | samples_taken                                     | is high, no back-pressure
// config    | psel, penable, pwrite, paddr, pwdata, prdata,     | APB write in access phase,
//           | pready                                            | pready tied high
//
// After reset a clearing pass zeroes both bin memories with busy high. Per request, sample
// reads then writes the bin pair (skipped when refused), read reads then captures the bin,
// clear zeroes both memories, find max costs one read and one add per bin up to its result.
// The result strobe done comes in the last busy cycle and busy falls in the next one.
// The result side cannot stall, so results are never held back.
module dual_latency_histogram_core
	import dlh_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [OP_W-1:0]        op,
	input  logic [LAT_W-1:0]       isr_latency,
	input  logic [LAT_W-1:0]       sched_latency,
	input  logic                   which_hist,
	input  logic [BIN_IDX_W-1:0]   bin_index,
	output logic                   done,
	output logic                   accepted,
	output logic [COUNT_WIDTH-1:0] bin_count,
	output logic [MAXLAT_W-1:0]    max_latency,
	output logic [COUNT_WIDTH-1:0] overflow_count,
	output logic [COUNT_WIDTH-1:0] samples_taken,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	dlh_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dlh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dlh_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.isr_latency    (isr_latency),
		.sched_latency  (sched_latency),
		.which_hist     (which_hist),
		.bin_index      (bin_index),
		.sts            (sts),
		.accepted       (accepted),
		.bin_count      (bin_count),
		.max_latency    (max_latency),
		.overflow_count (overflow_count),
		.samples_taken  (samples_taken)
	);

endmodule

// ----- rtl/dlh_checker.sv -----
module dlh_checker
	import dlh_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic                   accepted,
	input logic [COUNT_WIDTH-1:0] bin_count,
	input logic [MAXLAT_W-1:0]    max_latency,
	input logic [COUNT_WIDTH-1:0] samples_taken
);

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("Result strobe seen while the block was idle.");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("Block stayed busy after delivering its result.");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted request did not raise busy.");

	a_sample_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (bin_count == '0 && max_latency == '0
			&& samples_taken != '0))
		else $error("Counted sample returned inconsistent result fields.");

endmodule

bind dual_latency_histogram_core dlh_checker u_dlh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.accepted      (accepted),
	.bin_count     (bin_count),
	.max_latency   (max_latency),
	.samples_taken (samples_taken)
);

// ----- tb/tb_dual_latency_histogram_core.sv -----
module tb_dual_latency_histogram_core
	import dlh_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		op_t              op;
		logic [LAT_W-1:0] isr_lat;
		logic [LAT_W-1:0] sched_lat;
		logic             which;
		logic [BIN_IDX_W-1:0] idx;
	} hist_request_t;

	typedef struct {
		logic                   accepted;
		logic [COUNT_WIDTH-1:0] bin_count;
		logic [MAXLAT_W-1:0]    max_latency;
		logic [COUNT_WIDTH-1:0] overflow_count;
		logic [COUNT_WIDTH-1:0] samples_taken;
	} hist_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [OP_W-1:0]        op = '0;
	logic [LAT_W-1:0]       isr_latency = '0;
	logic [LAT_W-1:0]       sched_latency = '0;
	logic                   which_hist = 1'b0;
	logic [BIN_IDX_W-1:0]   bin_index = '0;
	logic                   done;
	logic                   accepted;
	logic [COUNT_WIDTH-1:0] bin_count;
	logic [MAXLAT_W-1:0]    max_latency;
	logic [COUNT_WIDTH-1:0] overflow_count;
	logic [COUNT_WIDTH-1:0] samples_taken;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PADDR_W-1:0]     paddr = '0;
	logic [PDATA_W-1:0]     pwdata = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	logic [COUNT_WIDTH-1:0]   isr_hist [ISR_DEPTH];
	logic [COUNT_WIDTH-1:0]   sched_hist [SCHED_DEPTH];
	logic [COUNT_WIDTH-1:0]   hist_samples;
	logic [ISR_RANGE_W-1:0]   cfg_isr_range;
	logic [SCHED_RANGE_W-1:0] cfg_sched_range;
	logic [PERIOD_W-1:0]      cfg_period;

	hist_result_t replies_due[$];
	int           mismatches = 0;
	bit           no_gaps = 1'b0;

	always #2 clk = ~clk;

	dual_latency_histogram_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.isr_latency(isr_latency),
		.sched_latency(sched_latency),
		.which_hist(which_hist),
		.bin_index(bin_index),
		.done(done),
		.accepted(accepted),
		.bin_count(bin_count),
		.max_latency(max_latency),
		.overflow_count(overflow_count),
		.samples_taken(samples_taken),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	function automatic int unsigned isr_span();
		return (32'(cfg_isr_range) < 32'(ISR_DEPTH - 1)) ? 32'(cfg_isr_range)
			: 32'(ISR_DEPTH - 1);
	endfunction

	function automatic int unsigned sched_span();
		return (32'(cfg_sched_range) < 32'(SCHED_DEPTH - 1)) ? 32'(cfg_sched_range)
			: 32'(SCHED_DEPTH - 1);
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] bin_of(logic which, int unsigned i);
		return which ? sched_hist[i] : isr_hist[i];
	endfunction

	function automatic void reset_histograms();
		isr_hist = '{default: '0};
		sched_hist = '{default: '0};
		hist_samples = '0;
	endfunction

	function automatic hist_result_t apply_hist_op(hist_request_t r);
		int unsigned       ir;
		int unsigned       sr;
		int unsigned       rng;
		int unsigned       slot;
		int unsigned       i;
		longint unsigned   sum;
		hist_result_t      res;
		ir = isr_span();
		sr = sched_span();
		rng = r.which ? sr : ir;
		res = '{default: '0};
		case (r.op)
			OP_SAMPLE: begin
				if (hist_samples < cfg_period && hist_samples < COUNT_MAX) begin
					slot = (32'(r.isr_lat) < ir) ? 32'(r.isr_lat) : ir;
					if (isr_hist[slot] < COUNT_MAX)
						isr_hist[slot] = isr_hist[slot] + 1'b1;
					slot = (32'(r.sched_lat) < sr) ? 32'(r.sched_lat) : sr;
					if (sched_hist[slot] < COUNT_MAX)
						sched_hist[slot] = sched_hist[slot] + 1'b1;
					hist_samples = hist_samples + 1'b1;
					res.accepted = 1'b1;
				end
			end
			OP_READ: begin
				slot = (32'(r.idx) < rng) ? 32'(r.idx) : rng;
				res.bin_count = bin_of(r.which, slot);
			end
			OP_FINDMAX: begin
				res.max_latency = rng[MAXLAT_W-1:0];
				sum = 0;
				for (i = 0; i <= rng; i++) begin
					sum += 64'(bin_of(r.which, i));
					if (sum >= 64'(hist_samples)) begin
						res.max_latency = i[MAXLAT_W-1:0];
						break;
					end
				end
			end
			default: reset_histograms();
		endcase
		res.overflow_count = bin_of(r.which, rng);
		res.samples_taken = hist_samples;
		return res;
	endfunction

	function automatic hist_request_t mk_req(op_t o, int unsigned il, int unsigned sl,
			logic which, int unsigned idx);
		hist_request_t r;
		r.op = o;
		r.isr_lat = il[LAT_W-1:0];
		r.sched_lat = sl[LAT_W-1:0];
		r.which = which;
		r.idx = idx[BIN_IDX_W-1:0];
		return r;
	endfunction

	function automatic logic [LAT_W-1:0] pick_latency(int unsigned rng);
		case ($urandom_range(0, 9))
			0: return '1;
			1: return LAT_W'($urandom());
			2: return LAT_W'(rng + $urandom_range(0, 2));
			default: return LAT_W'($urandom_range(0, (rng < 64) ? rng + 2 : 63));
		endcase
	endfunction

	function automatic hist_request_t rand_req(int unsigned findmax_weight);
		hist_request_t r;
		int unsigned   roll;
		int unsigned   span;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			r.op = OP_CLEAR;
		else if (roll < 3 + findmax_weight)
			r.op = OP_FINDMAX;
		else if (roll < 25 + findmax_weight)
			r.op = OP_READ;
		else
			r.op = OP_SAMPLE;
		r.isr_lat = pick_latency(isr_span());
		r.sched_lat = pick_latency(sched_span());
		r.which = 1'($urandom_range(0, 1));
		span = r.which ? sched_span() : isr_span();
		if ($urandom_range(0, 9) < 3)
			r.idx = BIN_IDX_W'($urandom());
		else
			r.idx = BIN_IDX_W'($urandom_range(0, span + 2));
		return r;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		hist_result_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("result strobe with no request outstanding");
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				check_field("accepted", want.accepted, accepted);
				check_field("bin_count", want.bin_count, bin_count);
				check_field("max_latency", want.max_latency, max_latency);
				check_field("overflow_count", want.overflow_count, overflow_count);
				check_field("samples_taken", want.samples_taken, samples_taken);
			end
		end
	end

	task automatic issue_request(input hist_request_t r);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= r.op;
		isr_latency <= r.isr_lat;
		sched_latency <= r.sched_lat;
		which_hist <= r.which;
		bin_index <= r.idx;
		do @(posedge clk); while (busy);
		replies_due.push_back(apply_hist_op(r));
	endtask

	task automatic wait_for_idle();
		start <= 1'b0;
		while (replies_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ISR_RANGE:   cfg_isr_range = data[ISR_RANGE_W-1:0];
			REG_SCHED_RANGE: cfg_sched_range = data[SCHED_RANGE_W-1:0];
			default:         cfg_period = data[PERIOD_W-1:0];
		endcase
	endtask

	// Upper data bits are filled with noise; the block keeps only the field width.
	task automatic set_config(input int unsigned isr_r, input int unsigned sched_r,
			input int unsigned period);
		logic [PDATA_W-1:0] data;
		wait_for_idle();
		data = $urandom();
		data[ISR_RANGE_W-1:0] = isr_r[ISR_RANGE_W-1:0];
		write_reg(REG_ISR_RANGE, data);
		data = $urandom();
		data[SCHED_RANGE_W-1:0] = sched_r[SCHED_RANGE_W-1:0];
		write_reg(REG_SCHED_RANGE, data);
		data = $urandom();
		data[PERIOD_W-1:0] = period[PERIOD_W-1:0];
		write_reg(REG_PERIOD, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic test_empty_and_extremes();
		issue_request(mk_req(OP_FINDMAX, 0, 0, 1'b0, 0));
		issue_request(mk_req(OP_FINDMAX, 0, 0, 1'b1, 0));
		issue_request(mk_req(OP_READ, 0, 0, 1'b0, 8191));
		issue_request(mk_req(OP_SAMPLE, 0, 0, 1'b0, 0));
		issue_request(mk_req(OP_SAMPLE, 65535, 65535, 1'b1, 8191));
		issue_request(mk_req(OP_SAMPLE, 1000, 5000, 1'b0, 0));
		issue_request(mk_req(OP_SAMPLE, 999, 4999, 1'b1, 0));
		issue_request(mk_req(OP_READ, 0, 0, 1'b0, 1000));
		issue_request(mk_req(OP_READ, 0, 0, 1'b1, 8191));
		issue_request(mk_req(OP_READ, 0, 0, 1'b1, 4999));
		issue_request(mk_req(OP_FINDMAX, 0, 0, 1'b0, 0));
		issue_request(mk_req(OP_FINDMAX, 0, 0, 1'b1, 0));
		issue_request(mk_req(OP_CLEAR, 0, 0, 1'b0, 0));
		issue_request(mk_req(OP_READ, 0, 0, 1'b1, 0));
	endtask

	task automatic test_range_edges();
		set_config(0, 0, 100);
		issue_request(mk_req(OP_SAMPLE, 5, 7, 1'b0, 0));
		issue_request(mk_req(OP_READ, 0, 0, 1'b1, 9));
		issue_request(mk_req(OP_FINDMAX, 0, 0, 1'b0, 0));
		set_config(1023, 8191, 100);
		issue_request(mk_req(OP_SAMPLE, 65535, 65535, 1'b0, 0));
		issue_request(mk_req(OP_FINDMAX, 0, 0, 1'b0, 0));
		issue_request(mk_req(OP_READ, 0, 0, 1'b1, 8191));
		// One sample sits above the narrowed ranges, so the running sum falls short.
		set_config(10, 20, 100);
		issue_request(mk_req(OP_FINDMAX, 0, 0, 1'b0, 0));
		issue_request(mk_req(OP_FINDMAX, 0, 0, 1'b1, 0));
	endtask

	task automatic test_period_limit();
		set_config(7, 15, 2);
		issue_request(mk_req(OP_CLEAR, 0, 0, 1'b0, 0));
		repeat (4)
			issue_request(mk_req(OP_SAMPLE, $urandom_range(0, 9), $urandom_range(0, 17),
				1'b1, 0));
		set_config(7, 15, 0);
		issue_request(mk_req(OP_SAMPLE, 3, 3, 1'b0, 0));
		set_config(7, 15, 24'hFFFFFF);
		issue_request(mk_req(OP_SAMPLE, 3, 3, 1'b0, 0));
	endtask

	task automatic test_random_phases();
		int unsigned n_items;
		int unsigned fm_weight;
		for (int p = 0; p < 8; p++) begin
			n_items = 115;
			fm_weight = 17;
			case (p)
				0: set_config(7, 15, 40);
				1: set_config(0, 3, 24'hFFFFFF);
				2: set_config(31, 63, 25);
				3: begin
					set_config(1023, 8191, 150);
					n_items = 50;
					fm_weight = 4;
				end
				4: set_config(1, 1, 10);
				default: set_config($urandom_range(0, 63), $urandom_range(0, 127),
					$urandom_range(0, 60));
			endcase
			repeat (n_items) begin
				if ($urandom_range(0, 19) == 0)
					no_gaps = !no_gaps;
				issue_request(rand_req(fm_weight));
			end
		end
	endtask

	initial begin
		reset_histograms();
		cfg_isr_range = ISR_RANGE_RST;
		cfg_sched_range = SCHED_RANGE_RST;
		cfg_period = PERIOD_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		test_range_edges();
		test_period_limit();
		test_random_phases();
		wait_for_idle();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("dual_latency_histogram_core: match");
		else
			$display("dual_latency_histogram_core: mismatch");
		$finish;
	end

	initial begin
		#100000000;
		$display("dual_latency_histogram_core: mismatch");
		$finish;
	end

endmodule
